// ----- rtl/imadec_pkg.sv -----
// Shared types, constants and table functions of the IMA ADPCM block decoder.
// Used by every module of the decoder; depends on nothing else.

package imadec_pkg;

   localparam int MaxChannels   = 8;
   localparam int ChanWidth     = 3;
   localparam int ChanCountWidth = 4;
   localparam int QueueDepth    = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [15:0] MinBlockBytes = 16'd8;
   localparam logic [6:0]  StepIndexMax  = 7'd88;

   // Configuration register indexes.
   localparam logic [1:0] CsrBlockBytes   = 2'd0;
   localparam logic [1:0] CsrChannelCount = 2'd1;
   localparam logic [1:0] CsrLayoutMode   = 2'd2;

   // Byte positions within a channel header.
   localparam logic [1:0] HdrPosLow   = 2'd0;
   localparam logic [1:0] HdrPosHigh  = 2'd1;
   localparam logic [1:0] HdrPosIndex = 2'd2;
   localparam logic [1:0] HdrPosEmit  = 2'd3;

   localparam logic LayoutSplit = 1'b0;

   typedef logic signed [15:0] sample_type;

   typedef enum logic [2:0] {
      OpHdrLow,
      OpHdrHigh,
      OpHdrIndex,
      OpHdrEmit,
      OpData
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [ChanWidth-1:0]  ch;
      logic [7:0]            data;
   } cmd_type;

   localparam logic [14:0] StepTable [0:88] = '{
      15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
      15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
      15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
      15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
      15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
      15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
      15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
      15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
      15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
      15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086,
      15'd29794, 15'd32767
   };

   function automatic logic [14:0] step_size(input logic [6:0] idx);
      logic [14:0] s;
      if (idx > StepIndexMax) begin
         s = StepTable[StepIndexMax];
      end else begin
         s = StepTable[idx];
      end
      return s;
   endfunction

   function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
      logic [3:0] up;
      logic signed [4:0] adj;
      up = {2'b00, mag[1:0]} + 4'd1;
      if (mag[2]) begin
         adj = $signed({1'b0, up[2:0], 1'b0});
      end else begin
         adj = -5'sd1;
      end
      return adj;
   endfunction

   function automatic op_type header_op(input logic [1:0] pos);
      op_type op;
      unique case (pos)
         HdrPosLow:   op = OpHdrLow;
         HdrPosHigh:  op = OpHdrHigh;
         HdrPosIndex: op = OpHdrIndex;
         default:     op = OpHdrEmit;
      endcase
      return op;
   endfunction

endpackage

// ----- rtl/imadec_front.sv -----
// Front end of the IMA ADPCM block decoder: configuration registers, block position
// tracking and classification of each accepted byte into a decode command.
// Depends on imadec_pkg.

module imadec_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [1:0]                            csr_index,
   input  logic [15:0]                           csr_write_data,
   input  logic                                  req_valid,
   input  logic [7:0]                            req_data_byte,
   output logic                                  req_stall,
   input  logic                                  queue_full,
   output logic                                  push,
   output imadec_pkg::cmd_type                   cmd
);

   typedef enum logic [1:0] {
      StStart,
      StDivide,
      StLocate,
      StRun
   } state_type;

   state_type                                state_ff, state_in;
   logic [15:0]                              block_bytes_ff, block_bytes_in;
   logic [imadec_pkg::ChanCountWidth-1:0]    channel_count_ff, channel_count_in;
   logic                                     layout_mode_ff, layout_mode_in;
   logic [15:0]                              pos_ff, pos_in;
   logic [imadec_pkg::ChanCountWidth-1:0]    ch_ff, ch_in;
   logic [15:0]                              pp_ff, pp_in;
   logic [15:0]                              part_ff, part_in;
   logic [imadec_pkg::ChanCountWidth-1:0]    rem_ff, rem_in;
   logic [3:0]                               cnt_ff, cnt_in;
   logic [15:0]                              data_end_ff, data_end_in;

   logic [15:0]                              blk_eff;
   logic [imadec_pkg::ChanCountWidth-1:0]    chs_eff;
   logic [15:0]                              hdr_len;
   logic [imadec_pkg::ChanCountWidth:0]      rem_sh;
   logic                                     quo_bit;
   logic                                     accept;
   logic                                     cls_push;
   imadec_pkg::cmd_type                      cls_cmd;

   always_comb begin
      if (block_bytes_ff < imadec_pkg::MinBlockBytes) begin
         blk_eff = imadec_pkg::MinBlockBytes;
      end else begin
         blk_eff = block_bytes_ff;
      end
      if (channel_count_ff == '0) begin
         chs_eff = imadec_pkg::ChanCountWidth'(1);
      end else if (channel_count_ff > imadec_pkg::ChanCountWidth'(imadec_pkg::MaxChannels)) begin
         chs_eff = imadec_pkg::ChanCountWidth'(imadec_pkg::MaxChannels);
      end else begin
         chs_eff = channel_count_ff;
      end
      hdr_len = 16'({chs_eff, 2'b00});
   end

   assign req_stall = (state_ff != StRun) || queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cls_push     = 1'b0;
      cls_cmd.op   = imadec_pkg::OpData;
      cls_cmd.ch   = '0;
      cls_cmd.data = req_data_byte;
      if (layout_mode_ff == imadec_pkg::LayoutSplit) begin
         if (ch_ff < chs_eff) begin
            cls_push   = 1'b1;
            cls_cmd.ch = ch_ff[imadec_pkg::ChanWidth-1:0];
            if (pp_ff < 16'd4) begin
               cls_cmd.op = imadec_pkg::header_op(pp_ff[1:0]);
            end
         end
      end else begin
         if (pos_ff < hdr_len) begin
            cls_cmd.ch = pos_ff[4:2];
            cls_cmd.op = imadec_pkg::header_op(pos_ff[1:0]);
            cls_push   = (pos_ff[1:0] != imadec_pkg::HdrPosEmit) || (pos_ff[4:3] == 2'b00);
         end else if (chs_eff == imadec_pkg::ChanCountWidth'(1)) begin
            cls_push = 1'b1;
         end else if (pos_ff < data_end_ff) begin
            cls_push   = 1'b1;
            cls_cmd.ch = imadec_pkg::ChanWidth'(pos_ff[2] ^ chs_eff[0]);
         end
      end
   end

   assign push = accept && cls_push;
   assign cmd  = cls_cmd;

   assign rem_sh  = {rem_ff, part_ff[15]};
   assign quo_bit = rem_sh >= {1'b0, chs_eff};

   always_comb begin
      state_in         = state_ff;
      block_bytes_in   = block_bytes_ff;
      channel_count_in = channel_count_ff;
      layout_mode_in   = layout_mode_ff;
      pos_in           = pos_ff;
      ch_in            = ch_ff;
      pp_in            = pp_ff;
      part_in          = part_ff;
      rem_in           = rem_ff;
      cnt_in           = cnt_ff;
      data_end_in      = data_end_ff;
      if (csr_write_enable) begin
         state_in = StStart;
         unique case (csr_index)
            imadec_pkg::CsrBlockBytes:   block_bytes_in   = csr_write_data;
            imadec_pkg::CsrChannelCount: channel_count_in =
               csr_write_data[imadec_pkg::ChanCountWidth-1:0];
            imadec_pkg::CsrLayoutMode:   layout_mode_in   = csr_write_data[0];
            default: ;
         endcase
      end else begin
         unique case (state_ff)
            StStart: begin
               part_in = blk_eff;
               rem_in  = '0;
               cnt_in  = '0;
               if (pos_ff >= blk_eff) begin
                  pos_in = '0;
               end
               if (blk_eff > hdr_len) begin
                  data_end_in = hdr_len + ((blk_eff - hdr_len) & ~16'h0007);
               end else begin
                  data_end_in = hdr_len;
               end
               state_in = StDivide;
            end
            StDivide: begin
               if (quo_bit) begin
                  rem_in = imadec_pkg::ChanCountWidth'(rem_sh - {1'b0, chs_eff});
               end else begin
                  rem_in = rem_sh[imadec_pkg::ChanCountWidth-1:0];
               end
               part_in = {part_ff[14:0], quo_bit};
               cnt_in  = cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  ch_in    = '0;
                  pp_in    = pos_ff;
                  state_in = StLocate;
               end
            end
            StLocate: begin
               if ((ch_ff < chs_eff) && (pp_ff >= part_ff)) begin
                  pp_in = pp_ff - part_ff;
                  ch_in = ch_ff + imadec_pkg::ChanCountWidth'(1);
               end else begin
                  state_in = StRun;
               end
            end
            StRun: begin
               if (accept) begin
                  if ((pos_ff + 16'd1) == blk_eff) begin
                     pos_in = '0;
                     ch_in  = '0;
                     pp_in  = '0;
                  end else begin
                     pos_in = pos_ff + 16'd1;
                     if (ch_ff < chs_eff) begin
                        if ((pp_ff + 16'd1) == part_ff) begin
                           pp_in = '0;
                           ch_in = ch_ff + imadec_pkg::ChanCountWidth'(1);
                        end else begin
                           pp_in = pp_ff + 16'd1;
                        end
                     end
                  end
               end
            end
            default: state_in = StStart;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= StStart;
         block_bytes_ff   <= 16'd36;
         channel_count_ff <= imadec_pkg::ChanCountWidth'(1);
         layout_mode_ff   <= imadec_pkg::LayoutSplit;
         pos_ff           <= '0;
         ch_ff            <= '0;
         pp_ff            <= '0;
      end else begin
         state_ff         <= state_in;
         block_bytes_ff   <= block_bytes_in;
         channel_count_ff <= channel_count_in;
         layout_mode_ff   <= layout_mode_in;
         pos_ff           <= pos_in;
         ch_ff            <= ch_in;
         pp_ff            <= pp_in;
      end
      part_ff     <= part_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      data_end_ff <= data_end_in;
   end

endmodule

// ----- rtl/imadec_queue.sv -----
// Two-entry command queue between the front end and the decode back end.
// Depends on imadec_pkg.

module imadec_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  imadec_pkg::cmd_type  push_cmd,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output imadec_pkg::cmd_type  pop_cmd
);

   imadec_pkg::cmd_type                      slot_ff [imadec_pkg::QueueDepth];
   logic [imadec_pkg::QueuePtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [imadec_pkg::QueuePtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [imadec_pkg::QueueCntWidth-1:0]     count_ff, count_in;
   logic                                     do_push;
   logic                                     do_pop;

   assign full      = count_ff == imadec_pkg::QueueCntWidth'(imadec_pkg::QueueDepth);
   assign pop_valid = count_ff != '0;
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         if (wr_ptr_ff == imadec_pkg::QueuePtrWidth'(imadec_pkg::QueueDepth - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + imadec_pkg::QueuePtrWidth'(1);
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == imadec_pkg::QueuePtrWidth'(imadec_pkg::QueueDepth - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + imadec_pkg::QueuePtrWidth'(1);
         end
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + imadec_pkg::QueueCntWidth'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - imadec_pkg::QueueCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/imadec_back.sv -----
// Decode back end: per-channel predictor and step index registers, the IMA nibble
// update and the registered result word. Depends on imadec_pkg.

module imadec_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   input  imadec_pkg::cmd_type                 cmd,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [15:0]                  rsp_sample,
   output logic [imadec_pkg::ChanWidth-1:0]    rsp_channel,
   output logic                                rsp_last
);

   imadec_pkg::sample_type                  pred_ff [imadec_pkg::MaxChannels];
   logic [6:0]                              idx_ff  [imadec_pkg::MaxChannels];
   logic [7:0]                              low_ff, low_in;
   logic                                    half_ff, half_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   imadec_pkg::sample_type                  rsp_sample_ff, rsp_sample_in;
   logic [imadec_pkg::ChanWidth-1:0]        rsp_channel_ff, rsp_channel_in;
   logic                                    rsp_last_ff, rsp_last_in;

   imadec_pkg::sample_type                  pred_in;
   logic [6:0]                              idx_in;
   logic                                    pred_we;
   logic                                    idx_we;
   logic                                    advance;
   logic                                    produce;

   imadec_pkg::sample_type                  cur_pred;
   logic [6:0]                              cur_idx;
   logic [3:0]                              nib;
   logic [14:0]                             step;
   logic [16:0]                             diff;
   logic signed [17:0]                      diff_s;
   logic signed [17:0]                      sum;
   imadec_pkg::sample_type                  nib_pred;
   logic signed [8:0]                       ni;
   logic [6:0]                              nib_idx;

   assign cur_pred = pred_ff[cmd.ch];
   assign cur_idx  = idx_ff[cmd.ch];
   assign nib      = half_ff ? cmd.data[7:4] : cmd.data[3:0];
   assign step     = imadec_pkg::step_size(cur_idx);

   always_comb begin
      diff = 17'(step >> 3);
      if (nib[0]) begin
         diff = diff + 17'(step >> 2);
      end
      if (nib[1]) begin
         diff = diff + 17'(step >> 1);
      end
      if (nib[2]) begin
         diff = diff + 17'(step);
      end
      diff_s = $signed({1'b0, diff});
      sum    = 18'(cur_pred) + (nib[3] ? -diff_s : diff_s);
      if (sum > 18'sd32767) begin
         nib_pred = 16'sh7FFF;
      end else if (sum < -18'sd32768) begin
         nib_pred = 16'sh8000;
      end else begin
         nib_pred = sum[15:0];
      end
      if (cur_idx > imadec_pkg::StepIndexMax) begin
         ni = $signed({2'b00, imadec_pkg::StepIndexMax});
      end else begin
         ni = $signed({2'b00, cur_idx});
      end
      ni = ni + 9'(imadec_pkg::index_adjust(nib[2:0]));
      if (ni < 9'sd0) begin
         nib_idx = '0;
      end else if (ni > $signed({2'b00, imadec_pkg::StepIndexMax})) begin
         nib_idx = imadec_pkg::StepIndexMax;
      end else begin
         nib_idx = ni[6:0];
      end
   end

   assign advance = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pop            = 1'b0;
      produce        = 1'b0;
      pred_we        = 1'b0;
      idx_we         = 1'b0;
      pred_in        = nib_pred;
      idx_in         = nib_idx;
      low_in         = low_ff;
      half_in        = half_ff;
      rsp_sample_in  = nib_pred;
      rsp_channel_in = cmd.ch;
      rsp_last_in    = 1'b1;
      if (cmd_valid) begin
         unique case (cmd.op)
            imadec_pkg::OpHdrLow: begin
               low_in = cmd.data;
               pop    = 1'b1;
            end
            imadec_pkg::OpHdrHigh: begin
               pred_in = $signed({cmd.data, low_ff});
               pred_we = 1'b1;
               pop     = 1'b1;
            end
            imadec_pkg::OpHdrIndex: begin
               if (cmd.data > {1'b0, imadec_pkg::StepIndexMax}) begin
                  idx_in = imadec_pkg::StepIndexMax;
               end else begin
                  idx_in = cmd.data[6:0];
               end
               idx_we = 1'b1;
               pop    = 1'b1;
            end
            imadec_pkg::OpHdrEmit: begin
               if (advance) begin
                  rsp_sample_in = cur_pred;
                  produce       = 1'b1;
                  pop           = 1'b1;
               end
            end
            imadec_pkg::OpData: begin
               if (advance) begin
                  produce     = 1'b1;
                  pred_we     = 1'b1;
                  idx_we      = 1'b1;
                  rsp_last_in = half_ff;
                  half_in     = !half_ff;
                  pop         = half_ff;
               end
            end
            default: pop = 1'b1;
         endcase
      end
      if (advance) begin
         rsp_valid_in = produce;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
         low_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         half_ff      <= half_in;
         low_ff       <= low_in;
      end
      if (produce) begin
         rsp_sample_ff  <= rsp_sample_in;
         rsp_channel_ff <= rsp_channel_in;
         rsp_last_ff    <= rsp_last_in;
      end
      if (pred_we) begin
         pred_ff[cmd.ch] <= pred_in;
      end
      if (idx_we) begin
         idx_ff[cmd.ch] <= idx_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_sample  = rsp_sample_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// ----- rtl/ima_adpcm_block_decoder.sv -----
// IMA ADPCM block decoder, top level; depends on imadec_pkg, imadec_front,
// imadec_queue and imadec_back. Bytes of the data chunk enter one word per cycle
// while the two-entry command queue has room; the back end then decodes a data
// byte as two nibble updates, low nibble first, one nibble update a cycle while
// the output is not stalled, on the shared per-channel predictor and step index
// registers, and takes a header byte in a single update. A finished sample waits
// in the output register while rsp_stall is high; the queue keeps taking words
// until it is full, and then req_stall rises. After reset and after every
// configuration write the block keeps req_stall high while a 16-step divider
// works out the per-channel part length and the block position is mapped back
// onto a channel and an offset within its part.

module ima_adpcm_block_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [1:0]                          csr_index,
   input  logic [15:0]                         csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [15:0]                  rsp_sample,
   output logic [imadec_pkg::ChanWidth-1:0]    rsp_channel,
   output logic                                rsp_last
);

   logic                 queue_full;
   logic                 push;
   imadec_pkg::cmd_type  push_cmd;
   logic                 pop;
   logic                 pop_valid;
   imadec_pkg::cmd_type  pop_cmd;

   imadec_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_data_byte    (req_data_byte),
      .req_stall        (req_stall),
      .queue_full       (queue_full),
      .push             (push),
      .cmd              (push_cmd)
   );

   imadec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   imadec_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (pop_valid),
      .cmd         (pop_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_sample  (rsp_sample),
      .rsp_channel (rsp_channel),
      .rsp_last    (rsp_last)
   );

endmodule
